[design/ccd_pkg.sv]
// Shared types, register codes and the dot threshold table for the color correct / dither core.
`default_nettype none

package ccd_pkg;

  localparam int unsigned LANE_LAT  = 6;   // lane pipeline depth, input to curve result
  localparam int unsigned NUM_CHAN  = 3;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 10;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONTRAST   = 4'd0,
    REG_RED_MID    = 4'd1,
    REG_GREEN_MID  = 4'd2,
    REG_BLUE_MID   = 4'd3,
    REG_RED_BASE   = 4'd4,
    REG_GREEN_BASE = 4'd5,
    REG_BLUE_BASE  = 4'd6,
    REG_OUT_MODE   = 4'd7
  } ccd_reg_e;

  typedef enum logic [1:0] {
    MODE_RGB    = 2'd0,
    MODE_CMY    = 2'd1,
    MODE_DITHER = 2'd2,
    MODE_CURVE  = 2'd3
  } ccd_mode_e;

  // reset values
  localparam logic [9:0] CONTRAST_RST   = 10'd256;
  localparam logic [7:0] RED_MID_RST    = 8'd231;
  localparam logic [7:0] GREEN_MID_RST  = 8'd239;
  localparam logic [7:0] BLUE_MID_RST   = 8'd255;
  localparam logic [7:0] CURVE_BASE_RST = 8'd32;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [3:0] dot_row;
    logic [3:0] dot_col;
  } ccd_in_t;

  typedef struct packed {
    logic [7:0] red_or_cyan;
    logic [7:0] green_or_magenta;
    logic [7:0] blue_or_yellow;
  } ccd_out_t;

  // per-item side info carried alongside the lanes to the merge stage
  typedef struct packed {
    ccd_mode_e  mode;
    logic       black;
    logic [7:0] thr;
  } ccd_ctl_t;

  // 16x16 ordered dither thresholds, indexed {row, col}
  localparam logic [7:0] DOT_ROM [256] = '{
    8'd253,8'd245,8'd228,8'd240,8'd198,8'd183,8'd212,8'd182,
    8'd211,8'd197,8'd181,8'd210,8'd233,8'd227,8'd250,8'd254,
    8'd251,8'd234,8'd184,8'd213,8'd166,8'd143,8'd165,8'd142,
    8'd164,8'd141,8'd163,8'd152,8'd180,8'd223,8'd232,8'd244,
    8'd241,8'd221,8'd199,8'd144,8'd124,8'd100,8'd123,8'd99,
    8'd122,8'd98,8'd113,8'd131,8'd162,8'd196,8'd222,8'd226,
    8'd229,8'd185,8'd167,8'd114,8'd101,8'd84,8'd72,8'd71,
    8'd83,8'd70,8'd69,8'd97,8'd112,8'd140,8'd179,8'd239,
    8'd200,8'd153,8'd102,8'd125,8'd73,8'd49,8'd48,8'd47,
    8'd58,8'd46,8'd45,8'd68,8'd96,8'd132,8'd161,8'd195,
    8'd186,8'd168,8'd115,8'd74,8'd50,8'd34,8'd26,8'd25,
    8'd24,8'd23,8'd33,8'd44,8'd82,8'd111,8'd139,8'd178,
    8'd201,8'd145,8'd103,8'd75,8'd51,8'd27,8'd12,8'd11,
    8'd10,8'd9,8'd22,8'd43,8'd67,8'd95,8'd160,8'd209,
    8'd214,8'd169,8'd126,8'd85,8'd59,8'd28,8'd13,8'd3,
    8'd2,8'd8,8'd21,8'd42,8'd66,8'd94,8'd138,8'd177,
    8'd187,8'd146,8'd104,8'd76,8'd52,8'd29,8'd14,8'd4,
    8'd0,8'd7,8'd20,8'd57,8'd88,8'd121,8'd159,8'd219,
    8'd202,8'd154,8'd127,8'd77,8'd53,8'd30,8'd15,8'd16,
    8'd1,8'd6,8'd19,8'd41,8'd65,8'd93,8'd151,8'd194,
    8'd188,8'd147,8'd105,8'd86,8'd54,8'd35,8'd31,8'd32,
    8'd5,8'd18,8'd36,8'd40,8'd64,8'd120,8'd137,8'd176,
    8'd203,8'd155,8'd128,8'd106,8'd78,8'd55,8'd60,8'd56,
    8'd17,8'd38,8'd39,8'd81,8'd92,8'd110,8'd150,8'd208,
    8'd235,8'd215,8'd148,8'd116,8'd129,8'd79,8'd80,8'd87,
    8'd37,8'd62,8'd63,8'd91,8'd119,8'd136,8'd175,8'd231,
    8'd242,8'd189,8'd204,8'd170,8'd107,8'd117,8'd108,8'd118,
    8'd61,8'd90,8'd109,8'd130,8'd135,8'd207,8'd218,8'd225,
    8'd246,8'd236,8'd216,8'd190,8'd156,8'd171,8'd149,8'd172,
    8'd89,8'd157,8'd134,8'd158,8'd174,8'd193,8'd238,8'd249,
    8'd248,8'd252,8'd243,8'd230,8'd205,8'd220,8'd191,8'd217,
    8'd133,8'd206,8'd173,8'd192,8'd237,8'd224,8'd247,8'd255
  };

  function automatic logic [7:0] ccd_dot_thr(logic [3:0] row, logic [3:0] col);
    return DOT_ROM[{row, col}];
  endfunction

endpackage

`default_nettype wire

[design/ccd_lane.sv]
// One color channel: contrast mix followed by the Bezier tone curve, six register stages.
`default_nettype none

module ccd_lane
  import ccd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic [7:0] own_i,
  input  wire logic [7:0] oth_a_i,
  input  wire logic [7:0] oth_b_i,
  input  wire logic       bypass_i,   // curve-only mode: skip contrast
  input  wire logic [9:0] k_i,
  input  wire logic [7:0] mid_i,
  input  wire logic [7:0] base_i,
  output logic      [7:0] curve_o
);

  // contrast, stage 1: products
  logic        [17:0] prod_own_d, prod_own_q;
  logic signed [20:0] prod_oth_d, prod_oth_q;
  logic        [7:0]  raw_q;
  logic               bypass_q;
  logic        [8:0]  osum;
  logic signed [10:0] kd;

  always_comb begin
    osum       = {1'b0, oth_a_i} + {1'b0, oth_b_i};
    kd         = $signed({1'b0, k_i}) - 11'sd256;
    prod_own_d = {8'd0, k_i} * {10'd0, own_i};
    prod_oth_d = kd * $signed({1'b0, osum});
  end

  always_ff @(posedge clk_i) begin
    prod_own_q <= prod_own_d;
    prod_oth_q <= prod_oth_d;
    raw_q      <= own_i;
    bypass_q   <= bypass_i;
  end

  // contrast, stage 2: 2k*own - (k-256)*others, /512 toward zero, clamp
  logic signed [21:0] mix_n;
  logic        [7:0]  v_d, v_q;

  always_comb begin
    mix_n = $signed({3'd0, prod_own_q, 1'b0}) - $signed({prod_oth_q[20], prod_oth_q});
    if (bypass_q) begin
      v_d = raw_q;
    end else if (mix_n[21]) begin
      v_d = 8'd0;
    end else if (|mix_n[20:17]) begin
      v_d = 8'd255;
    end else begin
      v_d = mix_n[16:9];
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  // curve, stage 1: v(256-v), v^2, 3(mid-base)
  logic        [16:0] a_full;
  logic        [15:0] a_q, vv_d, vv_q;
  logic        [7:0]  v1_q;
  logic signed [8:0]  diff;
  logic signed [10:0] d3_d, d3_q;
  logic               sat1_q;

  always_comb begin
    a_full = {9'd0, v_q} * (17'd256 - {9'd0, v_q});
    vv_d   = {8'd0, v_q} * {8'd0, v_q};
    diff   = $signed({1'b0, mid_i}) - $signed({1'b0, base_i});
    d3_d   = $signed({diff[8], diff, 1'b0}) + $signed({{2{diff[8]}}, diff});
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_full[15:0];
    vv_q   <= vv_d;
    v1_q   <= v_q;
    d3_q   <= d3_d;
    sat1_q <= (v_q == 8'd255);
  end

  // curve, stage 2: 3(mid-base)v(256-v), v^3
  logic signed [27:0] m1_d, m1_q, m1b_q;
  logic        [23:0] vvv_d, vvv_q;
  logic               sat2_q, sat3_q;

  always_comb begin
    m1_d  = d3_q * $signed({1'b0, a_q});
    vvv_d = {8'd0, vv_q} * {16'd0, v1_q};
  end

  always_ff @(posedge clk_i) begin
    m1_q   <= m1_d;
    vvv_q  <= vvv_d;
    sat2_q <= sat1_q;
  end

  // curve, stage 3: v^3 (255-base)
  logic [31:0] m2_d, m2_q;

  always_comb begin
    m2_d = {8'd0, vvv_q} * {24'd0, 8'd255 - base_i};
  end

  always_ff @(posedge clk_i) begin
    m2_q   <= m2_d;
    m1b_q  <= m1_q;
    sat3_q <= sat2_q;
  end

  // curve, stage 4: sum in Q24 with rounding, floor and clamp
  logic signed [35:0] sum;
  logic        [7:0]  curve_d, curve_q;

  always_comb begin
    sum = $signed({m1b_q, 8'd0}) + $signed({4'd0, m2_q})
        + $signed({4'd0, base_i, 24'd0}) + 36'sh0_0080_0000;
    if (sat3_q) begin
      curve_d = 8'd255;
    end else if (sum[35]) begin
      curve_d = 8'd0;
    end else if (|sum[34:32]) begin
      curve_d = 8'd255;
    end else begin
      curve_d = sum[31:24];
    end
  end

  always_ff @(posedge clk_i) begin
    curve_q <= curve_d;
  end

  assign curve_o = curve_q;

endmodule

`default_nettype wire

[design/ccd_merge.sv]
// Merge stage: joins the three lane curves into RGB, CMY or dithered CMY and registers the result.
`default_nettype none

module ccd_merge
  import ccd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            vld_i,
  input  wire ccd_ctl_t        ctl_i,
  input  wire logic [2:0][7:0] curve_i,   // [0] red, [1] green, [2] blue
  output logic                 res_valid_o,
  output ccd_out_t             res_o
);

  logic [2:0][7:0] sel;
  logic [7:0]      cmy;
  ccd_out_t        res_d, res_q;
  logic            vld_q;

  always_comb begin
    for (int i = 0; i < NUM_CHAN; i++) begin
      cmy = ctl_i.black ? 8'd255 : (8'd255 - curve_i[i]);
      case (ctl_i.mode)
        MODE_RGB, MODE_CURVE: sel[i] = curve_i[i];
        MODE_CMY:             sel[i] = cmy;
        MODE_DITHER:          sel[i] = (ctl_i.thr >= cmy) ? 8'd0 : cmy;
        default:              sel[i] = curve_i[i];
      endcase
    end
    res_d.red_or_cyan      = sel[0];
    res_d.green_or_magenta = sel[1];
    res_d.blue_or_yellow   = sel[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = vld_q;
  assign res_o       = res_q;

  // black pixel in plain CMY prints full ink
  a_black_cmy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && $past(ctl_i.mode) == MODE_CMY && $past(ctl_i.black)
    |-> res_o == {8'd255, 8'd255, 8'd255})
    else $error("black pixel did not give full CMY");

  // dithered output is either off or above the dot threshold
  a_dither: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && $past(ctl_i.mode) == MODE_DITHER
    |-> (res_o.red_or_cyan == 8'd0 || res_o.red_or_cyan > $past(ctl_i.thr))
     && (res_o.green_or_magenta == 8'd0 || res_o.green_or_magenta > $past(ctl_i.thr))
     && (res_o.blue_or_yellow == 8'd0 || res_o.blue_or_yellow > $past(ctl_i.thr)))
    else $error("dithered value not above threshold");

  // RGB modes pass the lane curves straight through; red sits in the top byte
  a_rgb_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && ($past(ctl_i.mode) == MODE_RGB || $past(ctl_i.mode) == MODE_CURVE)
    |-> res_o == {$past(curve_i[0]), $past(curve_i[1]), $past(curve_i[2])})
    else $error("RGB mode altered curve value");

endmodule

`default_nettype wire

[design/color_correct_cmy_dither_core.sv]
// Top level: config registers, three channel lanes, side-info delay line and merge stage.
//
//   channel   ports                                     dir   transfer when
//   -------   ---------------------------------------   ---   --------------------------
//   pixel     start, busy, pix_i                        in    start && !busy
//   result    res_valid_o, res_o                        out   res_valid_o (one cycle)
//   config    cfg_valid_i, cfg_ready_o, cfg_index_i,    in    cfg_valid_i && cfg_ready_o
//             cfg_data_i
//
// One pixel per clock, every clock. The path from the start transfer to the result strobe
// is 2 stages of contrast mixing, 4 stages of tone curve (the multiplier chain
// v*v*v*(255-base) sets the depth) and 1 merge register. busy is always low and the
// config port is always ready. Reset clears the valid pipeline and loads the register
// reset values; payload registers are not reset. Results cannot be stalled.
`default_nettype none

module color_correct_cmy_dither_core
  import ccd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // pixel command
  input  wire logic                 start,
  output logic                      busy,
  input  wire ccd_in_t              pix_i,
  // result
  output logic                      res_valid_o,
  output ccd_out_t                  res_o,
  // configuration writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers; unused data bits are dropped on write.
  // ---------------------------------------------------------------------------
  logic [9:0]      contrast_q;
  logic [2:0][7:0] mid_q;
  logic [2:0][7:0] base_q;
  ccd_mode_e       mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contrast_q <= CONTRAST_RST;
      mid_q[0]   <= RED_MID_RST;
      mid_q[1]   <= GREEN_MID_RST;
      mid_q[2]   <= BLUE_MID_RST;
      base_q[0]  <= CURVE_BASE_RST;
      base_q[1]  <= CURVE_BASE_RST;
      base_q[2]  <= CURVE_BASE_RST;
      mode_q     <= MODE_RGB;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CONTRAST:   contrast_q <= cfg_data_i[9:0];
        REG_RED_MID:    mid_q[0]   <= cfg_data_i[7:0];
        REG_GREEN_MID:  mid_q[1]   <= cfg_data_i[7:0];
        REG_BLUE_MID:   mid_q[2]   <= cfg_data_i[7:0];
        REG_RED_BASE:   base_q[0]  <= cfg_data_i[7:0];
        REG_GREEN_BASE: base_q[1]  <= cfg_data_i[7:0];
        REG_BLUE_BASE:  base_q[2]  <= cfg_data_i[7:0];
        REG_OUT_MODE:   mode_q     <= ccd_mode_e'(cfg_data_i[1:0]);
        default:        ;  // writes past the register list are ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel transfer
  // ---------------------------------------------------------------------------
  logic            accept;
  logic [2:0][7:0] raw;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign raw[0] = pix_i.red_in;
  assign raw[1] = pix_i.green_in;
  assign raw[2] = pix_i.blue_in;

  // ---------------------------------------------------------------------------
  // Channel lanes: each mixes its own value against the other two, then curves it.
  // ---------------------------------------------------------------------------
  logic [2:0][7:0] curve;

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    ccd_lane u_lane (
      .clk_i    (clk_i),
      .own_i    (raw[c]),
      .oth_a_i  (raw[(c + 1) % NUM_CHAN]),
      .oth_b_i  (raw[(c + 2) % NUM_CHAN]),
      .bypass_i (mode_q == MODE_CURVE),
      .k_i      (contrast_q),
      .mid_i    (mid_q[c]),
      .base_i   (base_q[c]),
      .curve_o  (curve[c])
    );
  end

  // ---------------------------------------------------------------------------
  // Side info (mode, black flag, dot threshold) rides alongside the lanes.
  // ---------------------------------------------------------------------------
  ccd_ctl_t                 ctl_d;
  ccd_ctl_t                 ctl_q [LANE_LAT];
  logic     [LANE_LAT-1:0]  vld_q;

  always_comb begin
    ctl_d.mode  = mode_q;
    ctl_d.black = (raw[0] == 8'd0) && (raw[1] == 8'd0) && (raw[2] == 8'd0);
    ctl_d.thr   = ccd_dot_thr(pix_i.dot_row, pix_i.dot_col);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LANE_LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q[0] <= ctl_d;
    for (int i = 1; i < LANE_LAT; i++) begin
      ctl_q[i] <= ctl_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Merge and output register
  // ---------------------------------------------------------------------------
  ccd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (vld_q[LANE_LAT-1]),
    .ctl_i       (ctl_q[LANE_LAT-1]),
    .curve_i     (curve),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // every pixel that enters the pipe comes out as a result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> ##(LANE_LAT) res_valid_o)
    else $error("pixel lost in pipeline");

  // a strobe is only ever produced for a tracked pixel
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(vld_q[LANE_LAT-1]))
    else $error("result strobe without a pixel");

endmodule

`default_nettype wire
